[rtl/stpc_pkg.sv]
// Package for the stall protection trim controller.
// Types, register indexes, reset values and decision constants.
// No dependencies.
`default_nettype none

package stpc_pkg;

    localparam int unsigned AOA_W    = 16;
    localparam int unsigned HGT_W    = 19;
    localparam int unsigned TRIM_W   = 12;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned IVL_W    = 9;
    localparam int unsigned ALERT_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STALL_AOA      = 3'd0,
        REG_STALL_MIN_HGT  = 3'd1,
        REG_CAUTION_AOA    = 3'd2,
        REG_CAUTION_MIN_HGT = 3'd3,
        REG_RECOVER_AOA    = 3'd4,
        REG_TRIM_STEP      = 3'd5,
        REG_TRIM_FLOOR     = 3'd6,
        REG_RESTORE_BAND   = 3'd7
    } t_reg_idx;

    typedef enum logic [ALERT_W-1:0] {
        ALERT_NORMAL  = 2'd0,
        ALERT_CAUTION = 2'd1,
        ALERT_STALL   = 2'd2
    } t_alert;

    localparam logic [IVL_W-1:0] IVL_STALL   = 9'd10;
    localparam logic [IVL_W-1:0] IVL_CAUTION = 9'd50;
    localparam logic [IVL_W-1:0] IVL_SLOW    = 9'd250;
    localparam logic [IVL_W-1:0] IVL_IDLE    = 9'd500;

    localparam logic signed [TRIM_W-1:0] TRIM_WIN_LOW  = -12'sd1200;
    localparam logic signed [TRIM_W-1:0] TRIM_WIN_HIGH = 12'sd1100;
    localparam logic [CNT_W-1:0]         CNT_WRAP_LIMIT = 16'd100;
    localparam logic [CNT_W-1:0]         CNT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [13:0]               stall_aoa;
        logic [16:0]               stall_min_hgt;
        logic [13:0]               caution_aoa;
        logic [16:0]               caution_min_hgt;
        logic [13:0]               recover_aoa;
        logic [6:0]                trim_step;
        logic signed [TRIM_W-1:0]  trim_floor;
        logic [7:0]                restore_band;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        stall_aoa:       14'd1500,
        stall_min_hgt:   17'd600,
        caution_aoa:     14'd1200,
        caution_min_hgt: 17'd1520,
        recover_aoa:     14'd1000,
        trim_step:       7'd10,
        trim_floor:      -12'sd1000,
        restore_band:    8'd20
    };

    typedef struct packed {
        logic signed [TRIM_W-1:0] commanded;
        logic signed [TRIM_W-1:0] reference;
        logic                     episode;
        t_alert                   alert;
        logic [CNT_W-1:0]         total;
    } t_state;

    typedef struct packed {
        logic signed [AOA_W-1:0]  aoa;
        logic signed [HGT_W-1:0]  hgt;
        logic signed [TRIM_W-1:0] sim_trim;
    } t_sample;

    typedef struct packed {
        logic                     trim_write;
        logic [IVL_W-1:0]         interval;
    } t_flags;

endpackage

`default_nettype wire

[rtl/stpc_update.sv]
// Per-sample update logic: next controller state and result flags.
// Purely combinational; uses stpc_pkg.
`default_nettype none

module stpc_update (
    input  wire stpc_pkg::t_cfg    i_cfg,
    input  wire stpc_pkg::t_state  i_state,
    input  wire stpc_pkg::t_sample i_sample,
    output stpc_pkg::t_state       o_state,
    output stpc_pkg::t_flags       o_flags
);

    function automatic logic signed [stpc_pkg::TRIM_W-1:0] sat_trim(
        input logic signed [stpc_pkg::TRIM_W:0] v
    );
        logic signed [stpc_pkg::TRIM_W-1:0] r;
        begin
            if (v[stpc_pkg::TRIM_W] != v[stpc_pkg::TRIM_W-1]) begin
                r = v[stpc_pkg::TRIM_W] ? {1'b1, {(stpc_pkg::TRIM_W-1){1'b0}}}
                                        : {1'b0, {(stpc_pkg::TRIM_W-1){1'b1}}};
            end else begin
                r = v[stpc_pkg::TRIM_W-1:0];
            end
            return r;
        end
    endfunction

    logic signed [16:0] w_aoa;
    logic signed [19:0] w_hgt;
    logic               w_stall;
    logic               w_caution;
    logic               w_recover;
    logic signed [12:0] w_cmd;
    logic signed [12:0] w_ref;
    logic signed [12:0] w_step;
    logic signed [12:0] w_band;
    logic signed [12:0] w_dn;
    logic signed [12:0] w_up;
    logic signed [12:0] w_ref_hi;
    logic signed [12:0] w_ref_lo;

    assign w_aoa = {i_sample.aoa[15], i_sample.aoa};
    assign w_hgt = {i_sample.hgt[18], i_sample.hgt};

    assign w_stall   = (w_aoa > $signed({3'b000, i_cfg.stall_aoa}))
                    && (w_hgt > $signed({3'b000, i_cfg.stall_min_hgt}));
    assign w_caution = (w_aoa > $signed({3'b000, i_cfg.caution_aoa}))
                    && (w_hgt > $signed({3'b000, i_cfg.caution_min_hgt}));
    assign w_recover = (w_aoa < $signed({3'b000, i_cfg.recover_aoa}))
                    || (w_hgt < $signed({3'b000, i_cfg.stall_min_hgt}));

    assign w_cmd    = {i_state.commanded[11], i_state.commanded};
    assign w_ref    = {i_state.reference[11], i_state.reference};
    assign w_step   = {6'b000000, i_cfg.trim_step};
    assign w_band   = {5'b00000, i_cfg.restore_band};
    assign w_dn     = w_cmd - w_step;
    assign w_up     = w_cmd + w_step;
    assign w_ref_hi = w_ref + w_band;
    assign w_ref_lo = w_ref - w_band;

    always_comb begin
        o_state          = i_state;
        o_flags.trim_write = 1'b0;
        o_flags.interval   = stpc_pkg::IVL_SLOW;
        if (w_stall || w_caution) begin
            o_state.alert    = w_stall ? stpc_pkg::ALERT_STALL : stpc_pkg::ALERT_CAUTION;
            o_flags.interval = w_stall ? stpc_pkg::IVL_STALL : stpc_pkg::IVL_CAUTION;
            o_state.episode  = 1'b1;
            if (i_state.commanded > i_cfg.trim_floor) begin
                o_state.commanded  = sat_trim(w_dn);
                o_flags.trim_write = 1'b1;
            end
            if (i_state.total != stpc_pkg::CNT_MAX) begin
                o_state.total = i_state.total + 16'd1;
            end
        end else if (w_recover) begin
            if (i_state.episode) begin
                if (i_state.total > stpc_pkg::CNT_WRAP_LIMIT) begin
                    o_state.total = '0;
                end
                if (i_state.commanded > stpc_pkg::TRIM_WIN_LOW
                        && i_state.commanded < stpc_pkg::TRIM_WIN_HIGH) begin
                    if (w_cmd > w_ref_hi) begin
                        o_state.commanded  = sat_trim(w_dn);
                        o_flags.trim_write = 1'b1;
                        o_flags.interval   = stpc_pkg::IVL_STALL;
                    end else if (w_cmd < w_ref_lo) begin
                        o_state.commanded  = sat_trim(w_up);
                        o_flags.trim_write = 1'b1;
                        o_flags.interval   = stpc_pkg::IVL_STALL;
                    end else begin
                        o_state.episode = 1'b0;
                    end
                end
            end else begin
                o_flags.interval  = stpc_pkg::IVL_IDLE;
                o_state.alert     = stpc_pkg::ALERT_NORMAL;
                o_state.reference = i_sample.sim_trim;
                o_state.commanded = i_sample.sim_trim;
            end
        end else begin
            o_state.commanded = i_sample.sim_trim;
        end
    end

endmodule

`default_nettype wire

[rtl/stall_protection_trim_controller_unit.sv]
// Top level of the stall protection trim controller.
// Sample register, update logic (stpc_update) and result register; uses stpc_pkg.
//
// Usage:
//   Input channel: one sample word (angle of attack, height, current trim) is
//   taken when i_in_valid and o_in_ready are high at a rising edge.
//   Output channel: one result word per sample (trim strobe and value, alert,
//   poll interval, protecting flag, activation count), taken when
//   o_out_valid and i_out_ready are high.
//   Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx in the same
//   edge; write only while no sample is in flight.
//   Result path: an accepted sample goes into the sample register, then the
//   result register holding the updated controller state.
//   Throughput: one sample per cycle while the output is not stalled; the state
//   update is a single compare-and-step pass, so samples can follow back to back.
//   Stall: when the receiver holds i_out_ready low, the result stays put and
//   the sample register can still take one more word before o_in_ready drops.
//   Reset: synchronous, active low; config registers go to defaults, state is
//   cleared (trim zero, no episode, alert normal, count zero), pipeline empty.
`default_nettype none

module stall_protection_trim_controller_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire signed [stpc_pkg::AOA_W-1:0]      i_aoa_centideg,
    input  wire signed [stpc_pkg::HGT_W-1:0]      i_height_dm,
    input  wire signed [stpc_pkg::TRIM_W-1:0]     i_sim_trim,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_trim_write,
    output logic signed [stpc_pkg::TRIM_W-1:0]    o_trim_value,
    output logic [stpc_pkg::ALERT_W-1:0]          o_alert_level,
    output logic [stpc_pkg::IVL_W-1:0]            o_interval_ms,
    output logic                                  o_protecting,
    output logic [stpc_pkg::CNT_W-1:0]            o_activation_count,
    input  wire                                   i_cfg_we,
    input  wire [stpc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [stpc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    stpc_pkg::t_cfg    r_cfg;
    stpc_pkg::t_state  r_state;
    stpc_pkg::t_state  n_state;
    stpc_pkg::t_sample r_sample;
    stpc_pkg::t_flags  r_flags;
    stpc_pkg::t_flags  n_flags;
    logic              r_s1_valid;
    logic              r_out_valid;
    logic              w_s1_go;
    logic              w_in_take;

    assign w_s1_go    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_s1_go;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= stpc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (stpc_pkg::t_reg_idx'(i_cfg_idx))
                stpc_pkg::REG_STALL_AOA:       r_cfg.stall_aoa       <= i_cfg_data[13:0];
                stpc_pkg::REG_STALL_MIN_HGT:   r_cfg.stall_min_hgt   <= i_cfg_data[16:0];
                stpc_pkg::REG_CAUTION_AOA:     r_cfg.caution_aoa     <= i_cfg_data[13:0];
                stpc_pkg::REG_CAUTION_MIN_HGT: r_cfg.caution_min_hgt <= i_cfg_data[16:0];
                stpc_pkg::REG_RECOVER_AOA:     r_cfg.recover_aoa     <= i_cfg_data[13:0];
                stpc_pkg::REG_TRIM_STEP:       r_cfg.trim_step       <= i_cfg_data[6:0];
                stpc_pkg::REG_TRIM_FLOOR:      r_cfg.trim_floor      <= i_cfg_data[11:0];
                stpc_pkg::REG_RESTORE_BAND:    r_cfg.restore_band    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_sample.aoa      <= i_aoa_centideg;
            r_sample.hgt      <= i_height_dm;
            r_sample.sim_trim <= i_sim_trim;
        end
    end

    stpc_update u_update (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (r_sample),
        .o_state  (n_state),
        .o_flags  (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_valid) begin
            r_flags <= n_flags;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_trim_write       = r_flags.trim_write;
    assign o_interval_ms      = r_flags.interval;
    assign o_trim_value       = r_state.commanded;
    assign o_alert_level      = r_state.alert;
    assign o_protecting       = r_state.episode;
    assign o_activation_count = r_state.total;

`ifndef SYNTHESIS
    a_write_fast_ivl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.trim_write) |->
            (r_flags.interval == stpc_pkg::IVL_STALL
             || r_flags.interval == stpc_pkg::IVL_CAUTION))
        else $error("trim write with slow poll interval");

    a_idle_ivl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.interval == stpc_pkg::IVL_IDLE) |->
            (!r_state.episode && r_state.alert == stpc_pkg::ALERT_NORMAL
             && r_state.commanded == r_state.reference))
        else $error("idle interval while protecting");

    a_caution_ivl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.interval == stpc_pkg::IVL_CAUTION) |->
            (r_state.episode && r_state.alert == stpc_pkg::ALERT_CAUTION))
        else $error("caution interval without caution alert");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_s1_go || !r_s1_valid) |=> $stable(r_state))
        else $error("controller state changed without a sample");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && r_s1_valid && n_state.total != r_state.total
         && n_state.total != '0) |-> (n_state.total == r_state.total + 16'd1))
        else $error("activation count jumped");
`endif

endmodule

`default_nettype wire
